>>> src/tpu_pkg.sv
`default_nettype none

package tpu_pkg;

    localparam int ROWS_PER_PATTERN = 64;
    localparam int ROW_CNT_W        = $clog2(ROWS_PER_PATTERN + 1);
    localparam int ROW_IDX_W        = 6;

    localparam logic [7:0] NOTE_NONE    = 8'hFF;
    localparam logic [7:0] INST_NONE    = 8'h00;
    localparam logic [7:0] VOL_NONE     = 8'hFF;
    localparam logic [7:0] CMD_NONE     = 8'hFF;
    localparam logic [7:0] INFO_NONE    = 8'h00;
    localparam logic [7:0] ROW_END_BYTE = 8'h00;

    // pending flag bits: header bits 5, 6, 7
    localparam int FL_NOTE = 0;
    localparam int FL_VOL  = 1;
    localparam int FL_CMD  = 2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NOTE   = 3'd1,
        PH_INST   = 3'd2,
        PH_VOL    = 3'd3,
        PH_CMD    = 3'd4,
        PH_INFO   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row_index;
        logic [4:0]           channel;
        logic [7:0]           note;
        logic [7:0]           instrument;
        logic [7:0]           volume;
        logic [7:0]           command;
        logic [7:0]           command_info;
    } out_item_t;

    typedef struct packed {
        logic      emit;
        out_item_t item;
    } dec_result_t;

    typedef struct packed {
        phase_t               phase;
        logic [2:0]           flags;
        logic [ROW_CNT_W-1:0] row_count;
        logic [4:0]           channel;
        logic [7:0]           note;
        logic [7:0]           instrument;
        logic [7:0]           volume;
        logic [7:0]           command;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        phase:      PH_HEADER,
        flags:      3'b000,
        row_count:  '0,
        channel:    5'd0,
        note:       NOTE_NONE,
        instrument: INST_NONE,
        volume:     VOL_NONE,
        command:    CMD_NONE
    };

    // phase once the volume slot is reached or skipped
    function automatic phase_t from_vol(input logic [2:0] flags);
        phase_t ph;
        if (flags[FL_VOL])
            ph = PH_VOL;
        else if (flags[FL_CMD])
            ph = PH_CMD;
        else
            ph = PH_HEADER;
        return ph;
    endfunction

endpackage

`default_nettype wire

>>> src/tpu_if.sv
`default_nettype none

interface tpu_in_if;
    import tpu_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpu_out_if;
    import tpu_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/tpu_in_stage.sv
`default_nettype none

module tpu_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tpu_in_if.sink                 packed_stream,
    input  wire logic              step,
    output logic                   held_valid,
    output tpu_pkg::in_item_t      held_item
);
    import tpu_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    assign packed_stream.ready = !valid_reg || step;
    assign take = packed_stream.valid && packed_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (step)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= packed_stream.data;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

>>> src/tpu_decoder.sv
`default_nettype none

module tpu_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire tpu_pkg::in_item_t item,
    output tpu_pkg::dec_result_t   result
);
    import tpu_pkg::*;

    dec_state_t st_reg;
    dec_state_t st_work;
    dec_state_t st_next;
    logic [7:0] b;
    logic [7:0] info;
    logic       emit;

    assign b = item.packed_byte;

    always_comb
    begin
        st_work = st_reg;
        emit    = 1'b0;
        info    = INFO_NONE;
        if (st_reg.row_count < ROW_CNT_W'(ROWS_PER_PATTERN))
        begin
            unique case (st_reg.phase)
                PH_NOTE:
                begin
                    st_work.note  = b;
                    st_work.phase = PH_INST;
                end
                PH_INST:
                begin
                    st_work.instrument = b;
                    st_work.phase      = from_vol(st_reg.flags);
                    emit               = (st_work.phase == PH_HEADER);
                end
                PH_VOL:
                begin
                    st_work.volume = b;
                    st_work.phase  = st_reg.flags[FL_CMD] ? PH_CMD : PH_HEADER;
                    emit           = !st_reg.flags[FL_CMD];
                end
                PH_CMD:
                begin
                    st_work.command = b;
                    st_work.phase   = PH_INFO;
                end
                PH_INFO:
                begin
                    info          = b;
                    emit          = 1'b1;
                    st_work.phase = PH_HEADER;
                end
                default:
                begin
                    st_work.phase = PH_HEADER;
                    if (b == ROW_END_BYTE)
                    begin
                        st_work.row_count = st_reg.row_count + 1'b1;
                    end
                    else
                    begin
                        st_work.channel    = b[4:0];
                        st_work.flags      = b[7:5];
                        st_work.note       = NOTE_NONE;
                        st_work.instrument = INST_NONE;
                        st_work.volume     = VOL_NONE;
                        st_work.command    = CMD_NONE;
                        st_work.phase      = b[5] ? PH_NOTE : from_vol(b[7:5]);
                        emit               = (b[7:5] == 3'b000);
                    end
                end
            endcase
        end

        st_next = item.last_byte ? STATE_RESET : st_work;

        result.emit                 = emit;
        result.item.row_index       = ROW_IDX_W'(st_reg.row_count);
        result.item.channel         = st_work.channel;
        result.item.note            = st_work.note;
        result.item.instrument      = st_work.instrument;
        result.item.volume          = st_work.volume;
        result.item.command         = st_work.command;
        result.item.command_info    = info;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= STATE_RESET;
        else if (step)
            st_reg <= st_next;
    end

endmodule

`default_nettype wire

>>> src/tpu_out_stage.sv
`default_nettype none

module tpu_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire tpu_pkg::dec_result_t result,
    output logic                     free,
    tpu_out_if.source                entry_stream
);
    import tpu_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    logic      load;

    assign free = !valid_reg || entry_stream.ready;
    assign load = step && result.emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (entry_stream.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= result.item;
    end

    assign entry_stream.valid = valid_reg;
    assign entry_stream.data  = item_reg;

endmodule

`default_nettype wire

>>> src/tracker_pattern_unpacker_top.sv
// Channel        Dir  Payload                                     Transfer
// packed_stream  in   packed_byte[7:0], last_byte                 valid & ready
// entry_stream   out  row_index[5:0], channel[4:0], note,         valid & ready
//                     instrument, volume, command, command_info
//
// One byte per cycle sustained while entry_stream accepts entries; each byte passes
// the input register, then is decoded into the result register.
// The decode state advances once per byte, on each step of the held byte.
// rst_n is asynchronous: both stages empty, decoder back to expecting a header.
// A stalled entry_stream holds the result register; a byte waits in the input
// register only when it would produce a new entry onto a full result register.
`default_nettype none

module tracker_pattern_unpacker_top (
    input  wire logic clk,
    input  wire logic rst_n,
    tpu_in_if.sink    packed_stream,
    tpu_out_if.source entry_stream
);
    import tpu_pkg::*;

    logic        held_valid;
    in_item_t    held_item;
    logic        out_free;
    logic        step;
    dec_result_t result;

    // decode a held byte when the result register can take whatever it yields
    assign step = held_valid && (out_free || !result.emit);

    tpu_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .packed_stream (packed_stream),
        .step          (step),
        .held_valid    (held_valid),
        .held_item     (held_item)
    );

    tpu_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (held_item),
        .result (result)
    );

    tpu_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .result       (result),
        .free         (out_free),
        .entry_stream (entry_stream)
    );

endmodule

`default_nettype wire

>>> test/unpacker_checker.sv
`timescale 1ns / 1ps

module unpacker_checker
    import tpu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tpu_in_if    packed_stream,
    tpu_out_if   entry_stream,
    output int   fails,
    output int   pending
);

    // shadow decoder state
    phase_t     ph;
    logic [2:0] flags;
    int         rows;
    logic [4:0] chan;
    logic [7:0] note;
    logic [7:0] inst;
    logic [7:0] vol;
    logic [7:0] cmd;

    out_item_t  awaited_entries[$];

    initial fails = 0;

    function automatic void clear_decoder();
        ph    = PH_HEADER;
        flags = 3'b000;
        rows  = 0;
        chan  = 5'd0;
        note  = NOTE_NONE;
        inst  = INST_NONE;
        vol   = VOL_NONE;
        cmd   = CMD_NONE;
    endfunction

    // advance the shadow decoder by one byte; returns 1 when an entry completes
    function automatic logic decode_byte(input logic [7:0] b, input logic last,
                                         output out_item_t entry);
        logic       done;
        logic [7:0] info;
        done  = 1'b0;
        info  = INFO_NONE;
        entry = '0;
        if (rows < ROWS_PER_PATTERN) begin
            case (ph)
                PH_NOTE:
                begin
                    note = b;
                    ph   = PH_INST;
                end
                PH_INST:
                begin
                    inst = b;
                    if (flags[FL_VOL])
                        ph = PH_VOL;
                    else if (flags[FL_CMD])
                        ph = PH_CMD;
                    else
                    begin
                        ph   = PH_HEADER;
                        done = 1'b1;
                    end
                end
                PH_VOL:
                begin
                    vol = b;
                    if (flags[FL_CMD])
                        ph = PH_CMD;
                    else
                    begin
                        ph   = PH_HEADER;
                        done = 1'b1;
                    end
                end
                PH_CMD:
                begin
                    cmd = b;
                    ph  = PH_INFO;
                end
                PH_INFO:
                begin
                    info = b;
                    ph   = PH_HEADER;
                    done = 1'b1;
                end
                default:
                begin
                    ph = PH_HEADER;
                    if (b == ROW_END_BYTE)
                        rows++;
                    else
                    begin
                        chan  = b[4:0];
                        flags = b[7:5];
                        note  = NOTE_NONE;
                        inst  = INST_NONE;
                        vol   = VOL_NONE;
                        cmd   = CMD_NONE;
                        if (flags[FL_NOTE])
                            ph = PH_NOTE;
                        else if (flags[FL_VOL])
                            ph = PH_VOL;
                        else if (flags[FL_CMD])
                            ph = PH_CMD;
                        else
                            done = 1'b1;
                    end
                end
            endcase
        end
        if (done)
            entry = '{row_index: rows[ROW_IDX_W-1:0], channel: chan, note: note,
                      instrument: inst, volume: vol, command: cmd, command_info: info};
        if (last)
            clear_decoder();
        return done;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            clear_decoder();
            awaited_entries.delete();
            pending <= 0;
        end
        else
        begin
            // results first: an entry can never leave in the cycle its byte arrives
            if (entry_stream.valid && entry_stream.ready)
            begin
                got = entry_stream.data;
                if (awaited_entries.size() == 0)
                begin
                    fails++;
                    $display("%0t: entry transfer with none expected, expected nothing, got %p",
                             $time, got);
                end
                else
                begin
                    want = awaited_entries.pop_front();
                    check_field("row_index", want.row_index, got.row_index);
                    check_field("channel", want.channel, got.channel);
                    check_field("note", want.note, got.note);
                    check_field("instrument", want.instrument, got.instrument);
                    check_field("volume", want.volume, got.volume);
                    check_field("command", want.command, got.command);
                    check_field("command_info", want.command_info, got.command_info);
                end
            end
            if (packed_stream.valid && packed_stream.ready)
            begin
                if (decode_byte(packed_stream.data.packed_byte, packed_stream.data.last_byte,
                                want))
                    awaited_entries.push_back(want);
            end
            pending <= awaited_entries.size();
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tpu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 365;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   cycles;
    int   src_idle;
    int   snk_stall;
    int   sent;

    tpu_in_if  packed_stream();
    tpu_out_if entry_stream();

    tracker_pattern_unpacker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .packed_stream (packed_stream),
        .entry_stream  (entry_stream)
    );

    unpacker_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .packed_stream (packed_stream),
        .entry_stream  (entry_stream),
        .fails         (fails),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
        entry_stream.ready <= ($urandom_range(99) >= snk_stall);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // present one byte, with random idle cycles in front, until it transfers
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle)
        begin
            packed_stream.valid <= 1'b0;
            @(posedge clk);
        end
        packed_stream.valid            <= 1'b1;
        packed_stream.data.packed_byte <= b;
        packed_stream.data.last_byte   <= last;
        @(posedge clk);
        while (!packed_stream.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        packed_stream.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] data_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // one pattern of well-formed rows, sometimes corrupted, cut short or left open
    task automatic random_pattern();
        logic [7:0] stream[$];
        logic [7:0] hdr;
        int         nrows;
        int         live;
        int         cut;
        int         kind;
        int         n_ent;
        int         i;
        logic       with_last;
        kind      = $urandom_range(99);
        nrows     = (kind < 6) ? $urandom_range(64, 66) : $urandom_range(1, 6);
        live      = -1;
        with_last = 1'b1;
        for (int r = 0; r < nrows; r++)
        begin
            n_ent = (nrows > 60) ? $urandom_range(0, 1) : $urandom_range(0, 4);
            for (int k = 0; k < n_ent; k++)
            begin
                hdr = 8'($urandom);
                if (hdr == ROW_END_BYTE)
                    hdr = 8'h20;
                stream.push_back(hdr);
                if (hdr[5])
                begin
                    stream.push_back(data_byte());
                    stream.push_back(data_byte());
                end
                if (hdr[6])
                    stream.push_back(data_byte());
                if (hdr[7])
                begin
                    stream.push_back(data_byte());
                    stream.push_back(data_byte());
                end
            end
            stream.push_back(ROW_END_BYTE);
            if (r == ROWS_PER_PATTERN - 1)
                live = stream.size();
        end
        cut = stream.size();
        if (kind >= 6 && kind < 18)
        begin
            // noise: scribble over a few bytes
            for (int n = $urandom_range(1, 4); n > 0; n--)
                stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom);
        end
        else if (kind >= 18 && kind < 30)
            cut = $urandom_range(1, stream.size());
        else if (kind >= 30 && kind < 36)
            with_last = 1'b0;
        for (i = 0; i < cut; i++)
            send_byte(stream[i], with_last && (i == cut - 1));
        sent += (live >= 0 && live < cut) ? live : cut;
    endtask

    initial
    begin
        rst_n                          = 1'b0;
        packed_stream.valid            = 1'b0;
        packed_stream.data.packed_byte = 8'h00;
        packed_stream.data.last_byte   = 1'b0;
        entry_stream.ready             = 1'b0;
        src_idle                       = 0;
        snk_stall                      = 0;
        sent                           = 0;
        cycles                         = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bare header, row end, all-flag entries at both data extremes,
        // each flag alone, entry closed by the final byte, then a cut-off entry
        send_byte(8'h01, 1'b0);
        send_byte(ROW_END_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        repeat (5) send_byte(8'h00, 1'b0);
        send_byte(8'hE0, 1'b0);
        repeat (5) send_byte(8'hFF, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h45, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'hE1, 1'b0);
        send_byte(8'h10, 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin src_idle = 0;  snk_stall = 0;  end
                1:       begin src_idle = 86; snk_stall = 0;  end
                2:       begin src_idle = 0;  snk_stall = 86; end
                default: begin src_idle = 16; snk_stall = 16; end
            endcase
            while (sent < (p + 1) * ITEMS_PER_PHASE)
            begin
                random_pattern();
                if ($urandom_range(99) < 4)
                    wait_drained();
            end
            wait_drained();
        end

        src_idle  = 0;
        snk_stall = 0;
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
